@@ src/kls_pkg.sv @@
// shared types and constants for the keyframe linear sampler
`default_nettype none
package kls_pkg;
   localparam int MaxKeys = 64;
   localparam int IdxW = $clog2(MaxKeys);
   localparam int CntW = 7;
   localparam logic [31:0] FixOne = 32'h0001_0000;

   localparam logic [0:0] CsrKeyCount = 1'd0;
   localparam logic [0:0] CsrFallback = 1'd1;

   localparam logic ModeLoad = 1'b0;
   localparam logic ModeSample = 1'b1;

   typedef struct packed {
      logic [31:0] t;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
   } key_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DIV,
      ST_MUL,
      ST_DONE
   } state_type;
endpackage
`default_nettype wire

@@ src/kls_cell.sv @@
// one key cell of the shift chain: holds one key and passes it to its neighbor
`default_nettype none
module kls_cell (
   input  wire logic clock,
   input  wire logic load,
   input  wire logic shift,
   input  kls_pkg::key_type load_key,
   input  kls_pkg::key_type prev_key,
   output kls_pkg::key_type key
);
   import kls_pkg::*;
   key_type key_ff;
   always_ff @(posedge clock) begin
      if (load) begin
         key_ff <= load_key;
      end else if (shift) begin
         key_ff <= prev_key;
      end
   end
   assign key = key_ff;
endmodule
`default_nettype wire

@@ src/kls_blend.sv @@
// divider and blend unit: bit-serial factor divide, then three multiplies
`default_nettype none
module kls_blend (
   input  wire logic clock,
   input  wire logic div_start,
   input  wire logic div_step,
   input  wire logic [31:0] num,
   input  wire logic [31:0] den,
   input  wire logic mul_step,
   input  kls_pkg::key_type lo_key,
   input  kls_pkg::key_type hi_key,
   output logic [31:0] res_x,
   output logic [31:0] res_y,
   output logic [31:0] res_z
);
   import kls_pkg::*;
   logic [47:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [33:0] trial;
   logic [32:0] dx, dy, dz;
   logic signed [50:0] px, py, pz;
   logic [31:0] rx_ff, ry_ff, rz_ff;

   assign trial = {rem_ff, quo_ff[47]} - {2'b00, den};
   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      if (div_start) begin
         quo_in = {num, 16'h0000};
         rem_in = '0;
      end else if (div_step) begin
         if (!trial[33]) begin
            rem_in = trial[32:0];
            quo_in = {quo_ff[46:0], 1'b1};
         end else begin
            rem_in = {rem_ff[31:0], quo_ff[47]};
            quo_in = {quo_ff[46:0], 1'b0};
         end
      end
   end
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign dx = {hi_key.x[31], hi_key.x} - {lo_key.x[31], lo_key.x};
   assign dy = {hi_key.y[31], hi_key.y} - {lo_key.y[31], lo_key.y};
   assign dz = {hi_key.z[31], hi_key.z} - {lo_key.z[31], lo_key.z};
   assign px = $signed(dx) * $signed({2'b00, quo_ff[15:0]});
   assign py = $signed(dy) * $signed({2'b00, quo_ff[15:0]});
   assign pz = $signed(dz) * $signed({2'b00, quo_ff[15:0]});

   always_ff @(posedge clock) begin
      if (mul_step) begin
         rx_ff <= lo_key.x + px[47:16];
         ry_ff <= lo_key.y + py[47:16];
         rz_ff <= lo_key.z + pz[47:16];
      end
   end
   assign res_x = rx_ff;
   assign res_y = ry_ff;
   assign res_z = rz_ff;
endmodule
`default_nettype wire

@@ src/keyframe_linear_sampler_top.sv @@
// top level of the keyframe linear sampler
//
// channel  ports   role
// req      req_*   load key or sample request in
// rsp      rsp_*   sample result out
// csr      csr_*   key count and fallback select
//
// a load is taken in the idle state, loads can follow back to back. a sample
// rotates the key chain through one full lap, then runs a 48-step serial
// divide, a registered blend and a registered output; the next request is
// taken once the result is valid. with one key or no interval the divide and
// blend are skipped.
// reset is synchronous and clears control only; a stalled rsp holds its
// result while the next sample runs, and that sample waits in ST_DONE.
`default_nettype none
module keyframe_linear_sampler_top (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic req_mode,
   input  wire logic [5:0] req_key_index,
   input  wire logic [31:0] req_time_req,
   input  wire logic [31:0] req_key_x,
   input  wire logic [31:0] req_key_y,
   input  wire logic [31:0] req_key_z,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic [31:0] rsp_out_x,
   output logic [31:0] rsp_out_y,
   output logic [31:0] rsp_out_z,
   output logic rsp_matched,
   output logic [5:0] rsp_interval_index,
   input  wire logic csr_write,
   input  wire logic [0:0] csr_index,
   input  wire logic [6:0] csr_data
);
   import kls_pkg::*;

   state_type state_ff, state_in;
   logic [CntW-1:0] count_ff;
   logic fb_ff;
   logic [31:0] t_ff;
   logic [IdxW:0] step_ff, step_in;
   logic [5:0] cnt_ff, cnt_in;
   logic found_ff, found_in;
   logic [IdxW-1:0] idx_ff, idx_in;
   key_type lo_ff, hi_ff;
   logic [CntW-1:0] n_eff;
   logic accept, shift, div_start, div_step, mul_step, hit, done_go;
   logic [31:0] res_x, res_y, res_z;
   logic [31:0] ox_ff, oy_ff, oz_ff;
   logic om_ff;
   logic [5:0] oi_ff;
   logic ov_ff;
   key_type load_key;
   key_type chain [MaxKeys];

   assign load_key = '{t: req_time_req, x: req_key_x, y: req_key_y, z: req_key_z};
   assign accept = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign done_go = (state_ff == ST_DONE) && (!ov_ff || rsp_ready);
   assign n_eff = (count_ff > CntW'(MaxKeys)) ? CntW'(MaxKeys) : count_ff;

   // chain rotates: last cell receives cell 0, so one full lap restores order
   for (genvar g = 0; g < MaxKeys; g++) begin : g_cell
      kls_cell u_cell (
         .clock   (clock),
         .load    (accept && req_mode == ModeLoad && req_key_index == IdxW'(g)),
         .shift   (shift),
         .load_key(load_key),
         .prev_key(chain[(g + 1) % MaxKeys]),
         .key     (chain[g])
      );
   end

   // chain[MaxKeys-1] holds key step, chain[0] holds key step+1 during scan
   assign hit = (step_ff < (IdxW+1)'(MaxKeys - 1))
      && ((step_ff + (IdxW+1)'(1)) < n_eff)
      && (t_ff >= chain[MaxKeys-1].t) && (t_ff < chain[0].t);

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      cnt_in = cnt_ff;
      found_in = found_ff;
      idx_in = idx_ff;
      shift = 1'b0;
      div_start = 1'b0;
      div_step = 1'b0;
      mul_step = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_mode == ModeSample) begin
               state_in = ST_SCAN;
               step_in = '0;
               found_in = 1'b0;
               shift = 1'b1;
            end
         end
         ST_SCAN: begin
            if (step_ff == (IdxW+1)'(MaxKeys)) begin
               if (n_eff == CntW'(1)) begin
                  state_in = ST_DONE;
               end else if (found_ff) begin
                  state_in = ST_DIV;
                  div_start = 1'b1;
                  cnt_in = '0;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               if (hit && !found_ff) begin
                  found_in = 1'b1;
                  idx_in = step_ff[IdxW-1:0];
               end
               step_in = step_ff + 1'b1;
               if (step_ff != (IdxW+1)'(MaxKeys - 1)) begin
                  shift = 1'b1;
               end
            end
         end
         ST_DIV: begin
            div_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'd47) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            mul_step = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (done_go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= CntW'(1);
         fb_ff <= 1'b0;
         ov_ff <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         found_ff <= found_in;
         if (csr_write) begin
            unique case (csr_index)
               CsrKeyCount: count_ff <= csr_data;
               CsrFallback: fb_ff <= csr_data[0];
               default: ;
            endcase
         end
         if (done_go) begin
            ov_ff <= 1'b1;
         end else if (rsp_ready) begin
            ov_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      cnt_ff <= cnt_in;
      idx_ff <= idx_in;
      if (accept) begin
         t_ff <= req_time_req;
      end
      if (state_ff == ST_SCAN && hit && !found_ff) begin
         lo_ff <= chain[MaxKeys-1];
         hi_ff <= chain[0];
      end
      if (done_go) begin
         if (n_eff == CntW'(1)) begin
            ox_ff <= chain[0].x;
            oy_ff <= chain[0].y;
            oz_ff <= chain[0].z;
            om_ff <= 1'b1;
            oi_ff <= '0;
         end else if (found_ff) begin
            ox_ff <= res_x;
            oy_ff <= res_y;
            oz_ff <= res_z;
            om_ff <= 1'b1;
            oi_ff <= 6'(idx_ff);
         end else begin
            ox_ff <= fb_ff ? FixOne : '0;
            oy_ff <= fb_ff ? FixOne : '0;
            oz_ff <= fb_ff ? FixOne : '0;
            om_ff <= 1'b0;
            oi_ff <= '0;
         end
      end
   end

   kls_blend u_blend (
      .clock    (clock),
      .div_start(div_start),
      .div_step (div_step),
      .num      (t_ff - lo_ff.t),
      .den      (hi_ff.t - lo_ff.t),
      .mul_step (mul_step),
      .lo_key   (lo_ff),
      .hi_key   (hi_ff),
      .res_x    (res_x),
      .res_y    (res_y),
      .res_z    (res_z)
   );

   assign rsp_valid = ov_ff;
   assign rsp_out_x = ox_ff;
   assign rsp_out_y = oy_ff;
   assign rsp_out_z = oz_ff;
   assign rsp_matched = om_ff;
   assign rsp_interval_index = oi_ff;
endmodule
`default_nettype wire
